// ===== design/yuva_pkg.sv =====
package yuva_pkg;

  // field and register widths
  localparam int PIX_W      = 8;
  localparam int BRIGHT_W   = 9;
  localparam int GAIN_W     = 11;
  localparam int CENTRE_W   = 8;
  localparam int TRIG_W     = 16;
  localparam int OFFS_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // pipeline depth, input beat to output register
  localparam int STAGES = 5;

  // range limits
  localparam int LUMA_MIN    = 16;
  localparam int LUMA_MAX    = 240;
  localparam int CHROMA_LIM  = 112;
  localparam int CHROMA_BIAS = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS      = 3'd0,
    REG_CONTRAST_GAIN   = 3'd1,
    REG_CONTRAST_CENTRE = 3'd2,
    REG_SATURATION_GAIN = 3'd3,
    REG_HUE_COS         = 3'd4,
    REG_HUE_SIN         = 3'd5,
    REG_CB_OFFSET       = 3'd6,
    REG_CR_OFFSET       = 3'd7
  } yuva_reg_t;

  typedef struct packed {
    logic signed [BRIGHT_W-1:0] brightness;
    logic signed [GAIN_W-1:0]   contrast_gain;
    logic        [CENTRE_W-1:0] contrast_centre;
    logic signed [GAIN_W-1:0]   saturation_gain;
    logic signed [TRIG_W-1:0]   hue_cos;
    logic signed [TRIG_W-1:0]   hue_sin;
    logic signed [OFFS_W-1:0]   cb_offset;
    logic signed [OFFS_W-1:0]   cr_offset;
  } yuva_cfg_t;

  localparam yuva_cfg_t CFG_RESET = '{
    brightness:      9'sd0,
    contrast_gain:   11'sd256,
    contrast_centre: 8'd128,
    saturation_gain: 11'sd256,
    hue_cos:         16'sd16384,
    hue_sin:         16'sd0,
    cb_offset:       9'sd0,
    cr_offset:       9'sd0
  };

endpackage

// ===== design/yuva_in_if.sv =====
interface yuva_in_if;
  import yuva_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma_in;
  logic [PIX_W-1:0] cb_in;
  logic [PIX_W-1:0] cr_in;
  logic             chroma_valid;

  modport source (output valid, output luma_in, output cb_in, output cr_in,
                  output chroma_valid, input ready);
  modport sink   (input valid, input luma_in, input cb_in, input cr_in,
                  input chroma_valid, output ready);
endinterface

// ===== design/yuva_out_if.sv =====
interface yuva_out_if;
  import yuva_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma_out;
  logic [PIX_W-1:0] cb_out;
  logic [PIX_W-1:0] cr_out;
  logic             chroma_valid_out;

  modport source (output valid, output luma_out, output cb_out, output cr_out,
                  output chroma_valid_out, input ready);
  modport sink   (input valid, input luma_out, input cb_out, input cr_out,
                  input chroma_valid_out, output ready);
endinterface

// ===== design/yuva_cfg_regs.sv =====
module yuva_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [yuva_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [yuva_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output yuva_pkg::yuva_cfg_t               cfg
);
  import yuva_pkg::*;

  yuva_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (yuva_reg_t'(cfg_idx))
        REG_BRIGHTNESS:      cfg_nxt.brightness      = $signed(cfg_wdata[BRIGHT_W-1:0]);
        REG_CONTRAST_GAIN:   cfg_nxt.contrast_gain   = $signed(cfg_wdata[GAIN_W-1:0]);
        REG_CONTRAST_CENTRE: cfg_nxt.contrast_centre = cfg_wdata[CENTRE_W-1:0];
        REG_SATURATION_GAIN: cfg_nxt.saturation_gain = $signed(cfg_wdata[GAIN_W-1:0]);
        REG_HUE_COS:         cfg_nxt.hue_cos         = $signed(cfg_wdata[TRIG_W-1:0]);
        REG_HUE_SIN:         cfg_nxt.hue_sin         = $signed(cfg_wdata[TRIG_W-1:0]);
        REG_CB_OFFSET:       cfg_nxt.cb_offset       = $signed(cfg_wdata[OFFS_W-1:0]);
        REG_CR_OFFSET:       cfg_nxt.cr_offset       = $signed(cfg_wdata[OFFS_W-1:0]);
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

// ===== design/yuva_luma_path.sv =====
module yuva_luma_path #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic [yuva_pkg::STAGES-1:0]       en,
  input  yuva_pkg::yuva_cfg_t               cfg,
  input  logic [yuva_pkg::PIX_W-1:0]        luma_in,
  output logic [yuva_pkg::PIX_W-1:0]        luma_out
);
  import yuva_pkg::*;

  localparam int DY_W   = PIX_W + 1;
  localparam int BIAS_W = CENTRE_W + 2;
  localparam int PROD_W = DY_W + GAIN_W;
  localparam int ACC_W  = ((PROD_W > BIAS_W + GAIN_FRAC_BITS) ?
                           PROD_W : BIAS_W + GAIN_FRAC_BITS) + 1;
  localparam int FLR_W  = ACC_W - GAIN_FRAC_BITS;

  logic signed [DY_W-1:0]   dy_r,   dy_nxt;
  logic signed [BIAS_W-1:0] bias1_r, bias1_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [BIAS_W-1:0] bias2_r;
  logic signed [ACC_W-1:0]  acc_r,  acc_nxt;
  logic signed [ACC_W-1:0]  bias_sh;
  logic signed [FLR_W-1:0]  flr;
  logic [PIX_W-1:0]         lum4_r, lum4_nxt;
  logic [PIX_W-1:0]         lum5_r;

  // stage 1: offset from the centre, integer bias
  always_comb begin
    dy_nxt    = $signed({1'b0, luma_in}) - $signed({1'b0, cfg.contrast_centre});
    bias1_nxt = BIAS_W'($signed(cfg.brightness))
              + BIAS_W'($signed({1'b0, cfg.contrast_centre}));
  end

  // stage 2: contrast product
  assign prod_nxt = PROD_W'(dy_r) * PROD_W'($signed(cfg.contrast_gain));

  // stage 3: add bias at gain scale
  always_comb begin
    bias_sh = ACC_W'(bias2_r) <<< GAIN_FRAC_BITS;
    acc_nxt = ACC_W'(prod_r) + bias_sh;
  end

  // stage 4: floor, clamp to video range
  always_comb begin
    flr = $signed(acc_r[ACC_W-1:GAIN_FRAC_BITS]);
    if (flr < FLR_W'(LUMA_MIN)) begin
      lum4_nxt = PIX_W'(LUMA_MIN);
    end else if (flr > FLR_W'(LUMA_MAX)) begin
      lum4_nxt = PIX_W'(LUMA_MAX);
    end else begin
      lum4_nxt = flr[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dy_r    <= dy_nxt;
      bias1_r <= bias1_nxt;
    end
    if (en[1]) begin
      prod_r  <= prod_nxt;
      bias2_r <= bias1_r;
    end
    if (en[2]) begin
      acc_r <= acc_nxt;
    end
    if (en[3]) begin
      lum4_r <= lum4_nxt;
    end
    if (en[4]) begin
      lum5_r <= lum4_r;
    end
  end

  assign luma_out = lum5_r;
endmodule

// ===== design/yuva_chroma_path.sv =====
module yuva_chroma_path #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic [yuva_pkg::STAGES-1:0]       en,
  input  yuva_pkg::yuva_cfg_t               cfg,
  input  logic [yuva_pkg::PIX_W-1:0]        cb_in,
  input  logic [yuva_pkg::PIX_W-1:0]        cr_in,
  input  logic                              chroma_valid,
  output logic [yuva_pkg::PIX_W-1:0]        cb_out,
  output logic [yuva_pkg::PIX_W-1:0]        cr_out,
  output logic                              chroma_valid_out
);
  import yuva_pkg::*;

  localparam int SH    = GAIN_FRAC_BITS + TRIG_FRAC_BITS;
  localparam int C_W   = PIX_W + 1;
  localparam int P_W   = TRIG_W + C_W;
  localparam int R_W   = P_W + 1;
  localparam int A_W   = GAIN_W + R_W;
  localparam int SUM_W = ((A_W > OFFS_W + SH) ? A_W : OFFS_W + SH) + 1;
  localparam int FLR_W = SUM_W - SH;
  localparam int PASS  = STAGES - 1;

  logic signed [C_W-1:0] u_r, u_nxt, v_r, v_nxt;
  logic signed [P_W-1:0] cu_r, sv_r, su_r, cv_r;
  logic signed [R_W-1:0] ru_r, ru_nxt, rv_r, rv_nxt;
  logic signed [A_W-1:0] au_r, av_r;
  logic signed [SUM_W-1:0] su_sum, sv_sum;
  logic signed [FLR_W-1:0] fu, fv;
  logic [PIX_W-1:0] cb_nxt, cr_nxt;
  logic [PIX_W-1:0] cb_out_r, cr_out_r;
  logic             cvo_r;

  // raw samples and flag ride along for the pass-through case
  logic [PIX_W-1:0] cb_d_r [PASS];
  logic [PIX_W-1:0] cr_d_r [PASS];
  logic             flg_d_r [PASS];

  function automatic logic [PIX_W-1:0] clamp_bias(logic signed [FLR_W-1:0] f);
    logic [PIX_W-1:0] res;
    if (f < -FLR_W'(CHROMA_LIM)) begin
      res = PIX_W'(CHROMA_BIAS - CHROMA_LIM);
    end else if (f > FLR_W'(CHROMA_LIM)) begin
      res = PIX_W'(CHROMA_BIAS + CHROMA_LIM);
    end else begin
      res = f[PIX_W-1:0] + PIX_W'(CHROMA_BIAS);
    end
    return res;
  endfunction

  // stage 1: remove bias
  always_comb begin
    u_nxt = $signed({1'b0, cb_in}) - C_W'(CHROMA_BIAS);
    v_nxt = $signed({1'b0, cr_in}) - C_W'(CHROMA_BIAS);
  end

  // stage 3: rotation sums
  always_comb begin
    ru_nxt = R_W'(cu_r) - R_W'(sv_r);
    rv_nxt = R_W'(su_r) + R_W'(cv_r);
  end

  // stage 5: offset, floor, clamp, re-bias
  always_comb begin
    su_sum = SUM_W'(au_r) + (SUM_W'($signed(cfg.cb_offset)) <<< SH);
    sv_sum = SUM_W'(av_r) + (SUM_W'($signed(cfg.cr_offset)) <<< SH);
    fu     = $signed(su_sum[SUM_W-1:SH]);
    fv     = $signed(sv_sum[SUM_W-1:SH]);
    if (flg_d_r[PASS-1]) begin
      cb_nxt = clamp_bias(fu);
      cr_nxt = clamp_bias(fv);
    end else begin
      cb_nxt = cb_d_r[PASS-1];
      cr_nxt = cr_d_r[PASS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
    end
    if (en[1]) begin
      cu_r <= P_W'($signed(cfg.hue_cos)) * P_W'(u_r);
      sv_r <= P_W'($signed(cfg.hue_sin)) * P_W'(v_r);
      su_r <= P_W'($signed(cfg.hue_sin)) * P_W'(u_r);
      cv_r <= P_W'($signed(cfg.hue_cos)) * P_W'(v_r);
    end
    if (en[2]) begin
      ru_r <= ru_nxt;
      rv_r <= rv_nxt;
    end
    if (en[3]) begin
      au_r <= A_W'($signed(cfg.saturation_gain)) * A_W'(ru_r);
      av_r <= A_W'($signed(cfg.saturation_gain)) * A_W'(rv_r);
    end
    if (en[4]) begin
      cb_out_r <= cb_nxt;
      cr_out_r <= cr_nxt;
      cvo_r    <= flg_d_r[PASS-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PASS; k++) begin
      if (en[k]) begin
        if (k == 0) begin
          cb_d_r[k]  <= cb_in;
          cr_d_r[k]  <= cr_in;
          flg_d_r[k] <= chroma_valid;
        end else begin
          cb_d_r[k]  <= cb_d_r[k-1];
          cr_d_r[k]  <= cr_d_r[k-1];
          flg_d_r[k] <= flg_d_r[k-1];
        end
      end
    end
  end

  assign cb_out           = cb_out_r;
  assign cr_out           = cr_out_r;
  assign chroma_valid_out = cvo_r;
endmodule

// ===== design/yuv_proc_amp_top.sv =====
// Video proc amp: brightness/contrast on luma, hue rotation, saturation
// and offsets on the Cb/Cr pair, with clamping to the 16..240 video range.
//
// Channels: in_if carries one pixel per beat (luma, Cb, Cr, chroma_valid);
// out_if returns one adjusted pixel per beat, in order. Both use valid/ready.
// Pixels without chroma_valid get luma adjusted and Cb/Cr passed unchanged.
// cfg_we/cfg_idx/cfg_wdata write the control registers, one per cycle;
// write them only while no pixel is in flight.
//
// Pipeline from input beat to output beat: prep, four products, rotation
// sum, saturation product, offset/clamp into the output register.
// Throughput, out_if ready: one pixel per cycle; multipliers fully pipelined.
//
// Reset (rst_n low, synchronous) empties the pipe and loads the default
// registers: unity contrast and saturation, zero hue, zero offsets.
// When out_if stalls, each stage holds its beat; empty stages still fill, so
// in_if.ready only drops once all five stages hold a pixel.
module yuv_proc_amp_top #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  yuva_in_if.sink                           in_if,
  yuva_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [yuva_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [yuva_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import yuva_pkg::*;

  yuva_cfg_t         cfg;
  logic [STAGES-1:0] vld_r, vld_nxt;
  logic [STAGES-1:0] adv;

  yuva_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // A stage loads when it is empty or its beat moves on downstream.
  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_if.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_if.valid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_if.ready  = adv[0];
  assign out_if.valid = vld_r[STAGES-1];

  yuva_luma_path #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_luma (
    .clk      (clk),
    .en       (adv),
    .cfg      (cfg),
    .luma_in  (in_if.luma_in),
    .luma_out (out_if.luma_out)
  );

  yuva_chroma_path #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_chroma (
    .clk              (clk),
    .en               (adv),
    .cfg              (cfg),
    .cb_in            (in_if.cb_in),
    .cr_in            (in_if.cr_in),
    .chroma_valid     (in_if.chroma_valid),
    .cb_out           (out_if.cb_out),
    .cr_out           (out_if.cr_out),
    .chroma_valid_out (out_if.chroma_valid_out)
  );

  // input beat lands in the first stage
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> vld_r[0])
    else $error("accepted beat missing from first stage");

  // back-pressure to the source only with a full pipe
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (&vld_r))
    else $error("input stalled with an empty stage");

  // a stalled result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |=> out_if.valid)
    else $error("stalled result lost");

  // register write lands
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_idx == REG_HUE_COS)) |=>
      (cfg.hue_cos == $signed($past(cfg_wdata[TRIG_W-1:0]))))
    else $error("hue cosine write not taken");
endmodule

// ===== verif/yuv_proc_amp_top_tb.sv =====
module yuv_proc_amp_top_tb;
  import yuva_pkg::*;

  // Fixed-point setup the block is built with; the predictor uses the same.
  localparam int GAIN_FRAC   = 8;
  localparam int TRIG_FRAC   = 14;
  localparam int CHROMA_FRAC = GAIN_FRAC + TRIG_FRAC;

  // Random part: phases of pixels, each under its own register setting.
  localparam int RAND_PHASES     = 10;
  localparam int BEATS_PER_PHASE = 44;

  // Generous ceiling: about 450 beats, each at worst a sender gap, a long
  // receiver stall and the pipe depth, plus a drain per phase.
  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_REPORTS = 40;

  // Hue pairs near the unit circle (0, 30, 45, 90, 120, 180, -75 degrees)
  // so that plausible phases produce chroma that is not all clamped.
  localparam int HUE_COS_TAB [7] = '{16384, 14189, 11585, 0, -8192, -16384, 4240};
  localparam int HUE_SIN_TAB [7] = '{0, 8192, 11585, 16384, 14189, 0, -15826};

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             cv;
  } pixel_t;

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

  // One row of the directed table: either a register write or a pixel beat,
  // the latter optionally with its result typed in by hand.
  typedef struct {
    row_kind_t               kind;
    yuva_reg_t               idx;
    logic [CFG_DATA_W-1:0]   data;
    pixel_t                  pix;
    bit                      typed;
    pixel_t                  want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  yuva_in_if  pix_in();
  yuva_out_if pix_out();

  yuv_proc_amp_top #(
    .GAIN_FRAC_BITS(GAIN_FRAC),
    .TRIG_FRAC_BITS(TRIG_FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (pix_in),
    .out_if   (pix_out),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the control registers, already sign-extended.
  longint amp_bright;
  longint amp_contrast;
  longint amp_centre;
  longint amp_sat;
  longint amp_cos;
  longint amp_sin;
  longint amp_cb_off;
  longint amp_cr_off;

  pixel_t    expected_pix[$];   // adjusted pixels still owed by the block
  stim_row_t directed_rows[$];
  int        mismatch_count;
  int        cycle_count;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_val(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Proc amp arithmetic at full precision, one floor per path (>>> on a
  // signed longint rounds toward minus infinity).
  function automatic pixel_t predict_pixel(pixel_t p);
    longint lacc, u, v, ru, rv, au, av;
    pixel_t r;
    lacc = (longint'(p.luma) - amp_centre) * amp_contrast
         + (amp_bright + amp_centre) * (longint'(1) << GAIN_FRAC);
    r.luma = PIX_W'(clamp_val(lacc >>> GAIN_FRAC, LUMA_MIN, LUMA_MAX));
    r.cv = p.cv;
    if (p.cv) begin
      u  = longint'(p.cb) - CHROMA_BIAS;
      v  = longint'(p.cr) - CHROMA_BIAS;
      ru = amp_cos * u - amp_sin * v;
      rv = amp_sin * u + amp_cos * v;
      au = amp_sat * ru + amp_cb_off * (longint'(1) << CHROMA_FRAC);
      av = amp_sat * rv + amp_cr_off * (longint'(1) << CHROMA_FRAC);
      r.cb = PIX_W'(clamp_val(au >>> CHROMA_FRAC, -CHROMA_LIM, CHROMA_LIM) + CHROMA_BIAS);
      r.cr = PIX_W'(clamp_val(av >>> CHROMA_FRAC, -CHROMA_LIM, CHROMA_LIM) + CHROMA_BIAS);
    end else begin
      // no chroma on this pixel: Cb/Cr ride through untouched
      r.cb = p.cb;
      r.cr = p.cr;
    end
    return r;
  endfunction

  function automatic stim_row_t pix_row(pixel_t p, bit typed, pixel_t want);
    stim_row_t row;
    row.kind  = ROW_PIXEL;
    row.idx   = REG_BRIGHTNESS;
    row.data  = '0;
    row.pix   = p;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(yuva_reg_t idx, logic [CFG_DATA_W-1:0] d);
    stim_row_t row;
    row.kind  = ROW_CONFIG;
    row.idx   = idx;
    row.data  = d;
    row.pix   = '0;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // Register value for a random phase: the range ends, raw 16-bit junk
  // (out of range, stray upper bits), or a value inside the range. The
  // plausible flavor keeps gains and offsets near unity / zero.
  function automatic logic [CFG_DATA_W-1:0] pick_setting(yuva_reg_t r, bit plausible);
    int lo, hi, v, pick;
    case (r)
      REG_CONTRAST_GAIN, REG_SATURATION_GAIN: begin
        lo = -512;
        hi = 512;
      end
      REG_CONTRAST_CENTRE: begin
        lo = 0;
        hi = 255;
      end
      REG_HUE_COS, REG_HUE_SIN: begin
        lo = -16384;
        hi = 16384;
      end
      default: begin
        lo = -255;
        hi = 255;
      end
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) v = lo;
    else if (pick == 1) v = hi;
    else if (pick == 2) v = int'($urandom);
    else if (plausible && (r == REG_CONTRAST_GAIN || r == REG_SATURATION_GAIN))
      v = int'($urandom_range(0, 272)) + 128;
    else if (plausible && r != REG_CONTRAST_CENTRE && lo == -255)
      v = int'($urandom_range(0, 80)) - 40;
    else
      v = int'($urandom_range(0, hi - lo)) + lo;
    return CFG_DATA_W'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // One register write at the next edge. The caller drops cfg_we after the
  // last write of a group, so back-to-back writes keep it high.
  task automatic write_reg(yuva_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_BRIGHTNESS:      amp_bright   = longint'($signed(data[BRIGHT_W-1:0]));
      REG_CONTRAST_GAIN:   amp_contrast = longint'($signed(data[GAIN_W-1:0]));
      REG_CONTRAST_CENTRE: amp_centre   = longint'(data[CENTRE_W-1:0]);
      REG_SATURATION_GAIN: amp_sat      = longint'($signed(data[GAIN_W-1:0]));
      REG_HUE_COS:         amp_cos      = longint'($signed(data[TRIG_W-1:0]));
      REG_HUE_SIN:         amp_sin      = longint'($signed(data[TRIG_W-1:0]));
      REG_CB_OFFSET:       amp_cb_off   = longint'($signed(data[OFFS_W-1:0]));
      REG_CR_OFFSET:       amp_cr_off   = longint'($signed(data[OFFS_W-1:0]));
      default: ;
    endcase
  endtask

  // Stop sending and wait until every owed pixel has come back.
  task automatic drain_pipe();
    pix_in.valid <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk);
  endtask

  // Present one pixel, hold it until the beat is taken, then log what the
  // block owes for it. Bursts of random length, random gaps in between;
  // a zero gap keeps valid high straight into the next beat.
  task automatic send_pixel(pixel_t p, bit typed, pixel_t want);
    int gap;
    pix_in.valid        <= 1'b1;
    pix_in.luma_in      <= p.luma;
    pix_in.cb_in        <= p.cb;
    pix_in.cr_in        <= p.cr;
    pix_in.chroma_valid <= p.cv;
    do @(posedge clk); while (!pix_in.ready);
    expected_pix.push_back(typed ? want : predict_pixel(p));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver back-pressure: cycles through free-running, light random,
  // periodic and heavy random stalls so gaps land on every pipe stage.
  initial begin : stall_pattern
    int tick;
    tick = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      case ((tick / 96) % 4)
        0:       pix_out.ready <= 1'b1;
        1:       pix_out.ready <= ($urandom_range(0, 3) != 0);
        2:       pix_out.ready <= ((tick % 7) < 4);
        default: pix_out.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Every output beat must match the oldest owed pixel, field by field.
  always @(posedge clk) begin : check_out
    pixel_t want;
    if (rst_n && pix_out.valid && pix_out.ready) begin
      if (expected_pix.size() == 0) begin
        report_mismatch("beat with nothing owed, luma_out", pix_out.luma_out, -1);
      end else begin
        want = expected_pix.pop_front();
        if (pix_out.luma_out !== want.luma)
          report_mismatch("luma_out", pix_out.luma_out, want.luma);
        if (pix_out.cb_out !== want.cb)
          report_mismatch("cb_out", pix_out.cb_out, want.cb);
        if (pix_out.cr_out !== want.cr)
          report_mismatch("cr_out", pix_out.cr_out, want.cr);
        if (pix_out.chroma_valid_out !== want.cv)
          report_mismatch("chroma_valid_out", pix_out.chroma_valid_out, want.cv);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d pixels owed", expected_pix.size());
      $display("yuv_proc_amp_top_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_t    px;
    yuva_reg_t reg_sel;
    bit        plausible;
    int        k;

    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 0;

    // shadow registers start at the reset values
    amp_bright   = $signed(CFG_RESET.brightness);
    amp_contrast = $signed(CFG_RESET.contrast_gain);
    amp_centre   = CFG_RESET.contrast_centre;
    amp_sat      = $signed(CFG_RESET.saturation_gain);
    amp_cos      = $signed(CFG_RESET.hue_cos);
    amp_sin      = $signed(CFG_RESET.hue_sin);
    amp_cb_off   = $signed(CFG_RESET.cb_offset);
    amp_cr_off   = $signed(CFG_RESET.cr_offset);

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= REG_BRIGHTNESS;
    cfg_wdata           <= '0;
    pix_in.valid        <= 1'b0;
    pix_in.luma_in      <= '0;
    pix_in.cb_in        <= '0;
    pix_in.cr_in        <= '0;
    pix_in.chroma_valid <= 1'b0;

    // Directed table. Under the reset setting the block is an identity
    // apart from the clamps, so those results are typed in directly.
    directed_rows.push_back(pix_row({8'd0, 8'd0, 8'd255, 1'b1}, 1'b1,
                                    {8'd16, 8'd16, 8'd240, 1'b1}));
    directed_rows.push_back(pix_row({8'd255, 8'd255, 8'd0, 1'b1}, 1'b1,
                                    {8'd240, 8'd240, 8'd16, 1'b1}));
    directed_rows.push_back(pix_row({8'd128, 8'd128, 8'd128, 1'b1}, 1'b1,
                                    {8'd128, 8'd128, 8'd128, 1'b1}));
    directed_rows.push_back(pix_row({8'd100, 8'd200, 8'd50, 1'b1}, 1'b1,
                                    {8'd100, 8'd200, 8'd50, 1'b1}));
    // no chroma: extreme Cb/Cr must pass through unclamped
    directed_rows.push_back(pix_row({8'd16, 8'd0, 8'd255, 1'b0}, 1'b1,
                                    {8'd16, 8'd0, 8'd255, 1'b0}));
    directed_rows.push_back(pix_row({8'd240, 8'd255, 8'd0, 1'b0}, 1'b1,
                                    {8'd240, 8'd255, 8'd0, 1'b0}));

    // every register at the top (or bottom) of its range
    directed_rows.push_back(reg_row(REG_BRIGHTNESS,      16'h00ff));
    directed_rows.push_back(reg_row(REG_CONTRAST_GAIN,   16'h0200));
    directed_rows.push_back(reg_row(REG_CONTRAST_CENTRE, 16'h0000));
    directed_rows.push_back(reg_row(REG_SATURATION_GAIN, 16'h0200));
    directed_rows.push_back(reg_row(REG_HUE_COS,         16'hc000));
    directed_rows.push_back(reg_row(REG_HUE_SIN,         16'h4000));
    directed_rows.push_back(reg_row(REG_CB_OFFSET,       16'hff01));
    directed_rows.push_back(reg_row(REG_CR_OFFSET,       16'h00ff));
    directed_rows.push_back(pix_row({8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0));
    directed_rows.push_back(pix_row({8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '0));
    directed_rows.push_back(pix_row({8'd3, 8'd128, 8'd128, 1'b0}, 1'b0, '0));

    // opposite extremes; hue_cos at -32768 and cr_offset at -256 lie past
    // the nominal range, cb_offset carries junk above its 9 bits
    directed_rows.push_back(reg_row(REG_BRIGHTNESS,      16'hff01));
    directed_rows.push_back(reg_row(REG_CONTRAST_GAIN,   16'hfe00));
    directed_rows.push_back(reg_row(REG_CONTRAST_CENTRE, 16'h00ff));
    directed_rows.push_back(reg_row(REG_SATURATION_GAIN, 16'hfe00));
    directed_rows.push_back(reg_row(REG_HUE_COS,         16'h8000));
    directed_rows.push_back(reg_row(REG_HUE_SIN,         16'h7fff));
    directed_rows.push_back(reg_row(REG_CB_OFFSET,       16'hfe00));
    directed_rows.push_back(reg_row(REG_CR_OFFSET,       16'h0100));
    directed_rows.push_back(pix_row({8'd0, 8'd1, 8'd254, 1'b1}, 1'b0, '0));
    directed_rows.push_back(pix_row({8'd255, 8'd128, 8'd0, 1'b1}, 1'b0, '0));
    directed_rows.push_back(pix_row({8'd200, 8'd17, 8'd99, 1'b0}, 1'b0, '0));

    // gains at the edge of their 11-bit fields, hue_sin at -32768
    directed_rows.push_back(reg_row(REG_BRIGHTNESS,      16'h0000));
    directed_rows.push_back(reg_row(REG_CONTRAST_GAIN,   16'h03ff));
    directed_rows.push_back(reg_row(REG_CONTRAST_CENTRE, 16'h0080));
    directed_rows.push_back(reg_row(REG_SATURATION_GAIN, 16'h0400));
    directed_rows.push_back(reg_row(REG_HUE_COS,         16'h4000));
    directed_rows.push_back(reg_row(REG_HUE_SIN,         16'h8000));
    directed_rows.push_back(reg_row(REG_CB_OFFSET,       16'h0000));
    directed_rows.push_back(reg_row(REG_CR_OFFSET,       16'h0000));
    directed_rows.push_back(pix_row({8'd129, 8'd129, 8'd127, 1'b1}, 1'b0, '0));
    directed_rows.push_back(pix_row({8'd127, 8'd130, 8'd131, 1'b1}, 1'b0, '0));
    directed_rows.push_back(pix_row({8'd170, 8'd85, 8'd170, 1'b1}, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain_pipe();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        if (i + 1 == directed_rows.size() || directed_rows[i + 1].kind != ROW_CONFIG)
          cfg_we <= 1'b0;
      end else begin
        send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: drain, rewrite some registers (all of them the first
    // time), then a run of random pixels. Odd phases use plausible gains
    // and a hue pair from the table so chroma stays mostly unclamped.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      plausible = (ph % 2 == 1);
      drain_pipe();
      reg_sel = reg_sel.first();
      do begin
        if (ph == 0 || $urandom_range(0, 2) != 0)
          write_reg(reg_sel, pick_setting(reg_sel, plausible));
        reg_sel = reg_sel.next();
      end while (reg_sel != reg_sel.first());
      if (plausible) begin
        k = $urandom_range(0, 6);
        write_reg(REG_HUE_COS, CFG_DATA_W'(HUE_COS_TAB[k]));
        write_reg(REG_HUE_SIN, CFG_DATA_W'(HUE_SIN_TAB[k]));
      end
      cfg_we <= 1'b0;

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        px.luma = PIX_W'($urandom);
        px.cb   = PIX_W'($urandom);
        px.cr   = PIX_W'($urandom);
        px.cv   = ($urandom_range(0, 3) != 0);
        send_pixel(px, 1'b0, '0);
      end
    end

    drain_pipe();
    repeat (STAGES + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_pix.size() == 0)
      $display("yuv_proc_amp_top_tb: PASS");
    else
      $display("yuv_proc_amp_top_tb: FAIL");
    $finish;
  end

endmodule
